// ===== sv/hsmq_pkg.sv =====
// Shared constants, types and codes for the sorted Huffman node queue.
package hsmq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int WEIGHT_BITS = 32;

    // fixed field widths of the ports
    localparam int FIELD_W = 32;
    localparam int ID_W    = 9;
    localparam int NID_W   = 10;
    localparam int OCC_W   = 9;
    localparam int SYM_W   = 8;

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WIDE_W    = (WEIGHT_BITS > FIELD_W) ? WEIGHT_BITS : FIELD_W;
    localparam int OCC_WIDE  = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    localparam logic [SYM_W-1:0] PARENT_SYMBOL = 8'h2A;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_MERGE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ONE   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [SYM_W-1:0]       symbol;
        logic [ID_W-1:0]        id;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   ins;    // sorted insert of ent
        logic   pop;    // drop the two head entries
        entry_t ent;
    } cell_ctl_t;

endpackage

// ===== sv/hsmq_cell.sv =====
// One queue slot: holds an entry and takes its next value from a neighbor or the bus.
module hsmq_cell (
    input  logic               clk,
    input  hsmq_pkg::cell_ctl_t ctl,
    input  logic               occ,      // slot lies below the entry count
    input  logic               prev_lt,  // left neighbor is lighter than the new entry
    input  hsmq_pkg::entry_t   left_ent,
    input  hsmq_pkg::entry_t   right2_ent,
    output logic               lt,
    output hsmq_pkg::entry_t   ent
);

    hsmq_pkg::entry_t q_reg;
    hsmq_pkg::entry_t q_next;

    assign lt  = occ && (q_reg.weight < ctl.ent.weight);
    assign ent = q_reg;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.pop)
        begin
            q_next = right2_ent;
        end
        else if (ctl.ins && !lt)
        begin
            // first slot not lighter takes the new entry, the rest shift right
            q_next = prev_lt ? ctl.ent : left_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== sv/huffman_sorted_merge_queue_top.sv =====
// Sorted Huffman node queue: a row of QUEUE_DEPTH cells kept in ascending weight
// order. On an insert every cell compares its weight with the new one and shifts
// right or loads in parallel. A merge first drops the two head cells (left shift by
// two) and registers the saturated sum, then in the merge state inserts the parent
// like a leaf. One request is worked on at a time; a new one is
// taken as soon as the result register is free or being emptied in the same cycle.
module huffman_sorted_merge_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  symbol,
    input  logic [31:0] weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [8:0]  node_id,
    output logic [8:0]  left_id,
    output logic [8:0]  right_id,
    output logic [31:0] node_weight,
    output logic [8:0]  occupancy
);

    localparam int DEPTH = hsmq_pkg::QUEUE_DEPTH;
    localparam int WB    = hsmq_pkg::WEIGHT_BITS;
    localparam int CW    = hsmq_pkg::CNT_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic                             state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [hsmq_pkg::NID_W-1:0]       nid_reg, nid_next;
    logic [WB-1:0]                    sum_reg, sum_next;
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       status_reg, status_next;
    logic [hsmq_pkg::ID_W-1:0]        node_id_reg, node_id_next;
    logic [hsmq_pkg::ID_W-1:0]        left_reg, left_next;
    logic [hsmq_pkg::ID_W-1:0]        right_reg, right_next;
    logic [WB-1:0]                    nweight_reg, nweight_next;
    logic [CW-1:0]                    occ_reg, occ_next;

    hsmq_pkg::cell_ctl_t              ctl;
    hsmq_pkg::entry_t                 q_w [DEPTH];
    logic                             lt_w [DEPTH];
    logic                             occ_w [DEPTH];

    logic                             acc;
    logic                             full;
    logic                             can_pop;
    logic [hsmq_pkg::WIDE_W-1:0]      w_wide;
    logic [WB-1:0]                    w_in;
    logic [WB:0]                      sum_full;
    logic [hsmq_pkg::WIDE_W-1:0]      nweight_wide;
    logic [hsmq_pkg::OCC_WIDE-1:0]    occ_wide;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign acc      = in_valid && in_ready;
    assign full     = (count_reg >= CW'(DEPTH));
    assign can_pop  = (count_reg >= CW'(2));

    assign w_wide   = hsmq_pkg::WIDE_W'(weight);
    assign w_in     = w_wide[WB-1:0];

    assign sum_full = {1'b0, q_w[0].weight} + {1'b0, q_w[1].weight};

    always_comb
    begin
        ctl.pop = acc && (cmd == hsmq_pkg::CMD_MERGE) && can_pop;
        ctl.ins = (acc && (cmd == hsmq_pkg::CMD_INSERT) && !full) || (state_reg == ST_MERGE);
        ctl.ent.id = nid_reg[hsmq_pkg::ID_W-1:0];
        if (state_reg == ST_MERGE)
        begin
            ctl.ent.weight = sum_reg;
            ctl.ent.symbol = hsmq_pkg::PARENT_SYMBOL;
        end
        else
        begin
            ctl.ent.weight = w_in;
            ctl.ent.symbol = symbol;
        end
    end

    // the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic             prev_lt_c;
            hsmq_pkg::entry_t left_c;
            hsmq_pkg::entry_t right2_c;

            assign occ_w[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_lt_c = 1'b1;
                assign left_c    = ctl.ent;
            end
            else
            begin : g_body
                assign prev_lt_c = lt_w[gi-1];
                assign left_c    = q_w[gi-1];
            end

            if (gi + 2 < DEPTH)
            begin : g_r2
                assign right2_c = q_w[gi+2];
            end
            else
            begin : g_tail
                // nothing valid shifts in past the end
                assign right2_c = q_w[gi];
            end

            hsmq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occ        (occ_w[gi]),
                .prev_lt    (prev_lt_c),
                .left_ent   (left_c),
                .right2_ent (right2_c),
                .lt         (lt_w[gi]),
                .ent        (q_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        nid_next       = nid_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        node_id_next   = node_id_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        nweight_next   = nweight_reg;
        occ_next       = occ_reg;

        if (state_reg == ST_MERGE)
        begin
            state_next     = ST_IDLE;
            count_next     = count_reg + CW'(1);
            nid_next       = nid_reg + hsmq_pkg::NID_W'(1);
            out_valid_next = 1'b1;
            status_next    = hsmq_pkg::STATUS_OK;
            node_id_next   = nid_reg[hsmq_pkg::ID_W-1:0];
            nweight_next   = sum_reg;
            occ_next       = count_reg + CW'(1);
        end
        else if (acc)
        begin
            out_valid_next = 1'b1;
            node_id_next   = '0;
            left_next      = '0;
            right_next     = '0;
            nweight_next   = '0;
            occ_next       = count_reg;
            if (cmd == hsmq_pkg::CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = hsmq_pkg::STATUS_FULL;
                end
                else
                begin
                    status_next  = hsmq_pkg::STATUS_OK;
                    node_id_next = nid_reg[hsmq_pkg::ID_W-1:0];
                    nweight_next = w_in;
                    count_next   = count_reg + CW'(1);
                    occ_next     = count_reg + CW'(1);
                    nid_next     = nid_reg + hsmq_pkg::NID_W'(1);
                end
            end
            else if (count_reg == '0)
            begin
                status_next = hsmq_pkg::STATUS_EMPTY;
            end
            else if (!can_pop)
            begin
                status_next = hsmq_pkg::STATUS_ONE;
            end
            else
            begin
                // result is posted together with the parent going back in
                out_valid_next = 1'b0;
                state_next     = ST_MERGE;
                count_next     = count_reg - CW'(2);
                left_next      = q_w[0].id;
                right_next     = q_w[1].id;
                sum_next       = sum_full[WB] ? '1 : sum_full[WB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            nid_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nid_reg       <= nid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        status_reg  <= status_next;
        node_id_reg <= node_id_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        nweight_reg <= nweight_next;
        occ_reg     <= occ_next;
    end

    assign nweight_wide = hsmq_pkg::WIDE_W'(nweight_reg);
    assign occ_wide     = hsmq_pkg::OCC_WIDE'(occ_reg);

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign node_id     = node_id_reg;
    assign left_id     = left_reg;
    assign right_id    = right_reg;
    assign node_weight = nweight_wide[hsmq_pkg::FIELD_W-1:0];
    assign occupancy   = occ_wide[hsmq_pkg::OCC_W-1:0];

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above queue depth");

    a_merge_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> !out_valid_reg)
        else $error("merge result would overwrite a pending result");

    a_merge_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |=> out_valid_reg && (status_reg == hsmq_pkg::STATUS_OK))
        else $error("merge finished without a result");

    a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        lt_w[1] |-> lt_w[0])
        else $error("queue order broken at the head");
`endif

endmodule

// ===== bench/huffman_sorted_merge_queue_top_tb.sv =====
// Self-checking bench for the sorted Huffman node queue: directed table, then random traffic and a fill-and-drain run.
module huffman_sorted_merge_queue_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_N       = 21;

    typedef struct packed {
        logic [1:0]                  status;
        logic [hsmq_pkg::ID_W-1:0]    node_id;
        logic [hsmq_pkg::ID_W-1:0]    left_id;
        logic [hsmq_pkg::ID_W-1:0]    right_id;
        logic [hsmq_pkg::FIELD_W-1:0] node_weight;
        logic [hsmq_pkg::OCC_W-1:0]   occupancy;
    } node_result_t;

    typedef struct packed {
        logic                         op;
        logic [hsmq_pkg::SYM_W-1:0]   sym;
        logic [hsmq_pkg::FIELD_W-1:0] wt;
        logic                         typed;
        node_result_t                 want;
    } dir_row_t;

    // Rows with typed = 1 carry a hand-written result; the rest go through the predictor.
    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b1,
            '{hsmq_pkg::STATUS_EMPTY, 9'd0, 9'd0, 9'd0, 32'h0000_0000, 9'd0}},
        '{hsmq_pkg::CMD_INSERT, 8'h00, 32'h0000_0000, 1'b1,
            '{hsmq_pkg::STATUS_OK, 9'd0, 9'd0, 9'd0, 32'h0000_0000, 9'd1}},
        '{hsmq_pkg::CMD_MERGE,  8'hFF, 32'hFFFF_FFFF, 1'b1,
            '{hsmq_pkg::STATUS_ONE, 9'd0, 9'd0, 9'd0, 32'h0000_0000, 9'd1}},
        '{hsmq_pkg::CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
            '{hsmq_pkg::STATUS_OK, 9'd1, 9'd0, 9'd0, 32'hFFFF_FFFF, 9'd2}},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b1,
            '{hsmq_pkg::STATUS_OK, 9'd2, 9'd0, 9'd1, 32'hFFFF_FFFF, 9'd1}},
        '{hsmq_pkg::CMD_INSERT, 8'h41, 32'hFFFF_FFFF, 1'b1,
            '{hsmq_pkg::STATUS_OK, 9'd3, 9'd0, 9'd0, 32'hFFFF_FFFF, 9'd2}},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b1,
            '{hsmq_pkg::STATUS_OK, 9'd4, 9'd3, 9'd2, 32'hFFFF_FFFF, 9'd1}},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b1,
            '{hsmq_pkg::STATUS_ONE, 9'd0, 9'd0, 9'd0, 32'h0000_0000, 9'd1}},
        '{hsmq_pkg::CMD_INSERT, 8'h10, 32'h0000_0001, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'h20, 32'h0000_0001, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'h55, 32'h8000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'hAA, 32'h8000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'h5A, 32'h5A5A_5A5A, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'hA5, 32'hA5A5_A5A5, 1'b0, '0},
        '{hsmq_pkg::CMD_INSERT, 8'h2A, 32'h7FFF_FFFF, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{hsmq_pkg::CMD_MERGE,  8'h00, 32'h0000_0000, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = hsmq_pkg::CMD_INSERT;
    logic [7:0]  symbol = '0;
    logic [31:0] weight = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [8:0]  node_id;
    logic [8:0]  left_id;
    logic [8:0]  right_id;
    logic [31:0] node_weight;
    logic [8:0]  occupancy;

    // predictor state
    hsmq_pkg::entry_t               sorted_nodes[$];
    logic [hsmq_pkg::NID_W-1:0]     next_node_id = '0;
    node_result_t                   pending_results[$];

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    node_result_t got_result, want_result;

    huffman_sorted_merge_queue_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .symbol(symbol),
        .weight(weight),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .node_id(node_id),
        .left_id(left_id),
        .right_id(right_id),
        .node_weight(node_weight),
        .occupancy(occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("huffman_sorted_merge_queue_top verification failed");
            $finish;
        end
    end

    function automatic void place_node(input hsmq_pkg::entry_t e);
        int pos;
        pos = 0;
        // new node goes ahead of every entry of equal weight
        while (pos < sorted_nodes.size() && sorted_nodes[pos].weight < e.weight)
            pos++;
        sorted_nodes.insert(pos, e);
    endfunction

    function automatic logic [hsmq_pkg::ID_W-1:0] grab_node_id();
        logic [hsmq_pkg::ID_W-1:0] id;
        id = next_node_id[hsmq_pkg::ID_W-1:0];
        next_node_id = next_node_id + 1'b1;
        return id;
    endfunction

    function automatic node_result_t apply_request(input logic op,
                                                   input logic [hsmq_pkg::SYM_W-1:0] sym,
                                                   input logic [hsmq_pkg::FIELD_W-1:0] wt);
        node_result_t r;
        hsmq_pkg::entry_t e, lo, hi;
        logic [hsmq_pkg::WEIGHT_BITS:0] sum;
        r = '0;
        e = '0;
        if (op == hsmq_pkg::CMD_INSERT)
        begin
            if (sorted_nodes.size() >= hsmq_pkg::QUEUE_DEPTH)
                r.status = hsmq_pkg::STATUS_FULL;
            else
            begin
                e.weight = wt;
                e.symbol = sym;
                e.id = grab_node_id();
                r.node_id = e.id;
                r.node_weight = e.weight;
                place_node(e);
            end
        end
        else if (sorted_nodes.size() == 0)
            r.status = hsmq_pkg::STATUS_EMPTY;
        else if (sorted_nodes.size() == 1)
            r.status = hsmq_pkg::STATUS_ONE;
        else
        begin
            lo = sorted_nodes.pop_front();
            hi = sorted_nodes.pop_front();
            sum = {1'b0, lo.weight} + {1'b0, hi.weight};
            e.weight = sum[hsmq_pkg::WEIGHT_BITS] ? {hsmq_pkg::WEIGHT_BITS{1'b1}}
                                                  : sum[hsmq_pkg::WEIGHT_BITS-1:0];
            e.symbol = hsmq_pkg::PARENT_SYMBOL;
            e.id = grab_node_id();
            r.left_id = lo.id;
            r.right_id = hi.id;
            r.node_id = e.id;
            r.node_weight = e.weight;
            place_node(e);
        end
        r.occupancy = hsmq_pkg::OCC_W'(sorted_nodes.size());
        return r;
    endfunction

    task automatic push_request(input logic op, input logic [hsmq_pkg::SYM_W-1:0] sym,
                                input logic [hsmq_pkg::FIELD_W-1:0] wt, input logic typed,
                                input node_result_t want);
        node_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = op;
        symbol = sym;
        weight = wt;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_request(op, sym, wt);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [hsmq_pkg::FIELD_W-1:0] random_weight();
        case ($urandom_range(9)) inside
            [0:3]: return $urandom_range(15);  // many ties
            4:
            begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            5: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_mix(input int n);
        int merge_pct;
        logic op;
        merge_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            // the merge share moves in bursts so occupancy wanders up and down
            if (i % 50 == 0)
                merge_pct = 15 + 17 * $urandom_range(4);
            op = ($urandom_range(99) < merge_pct) ? hsmq_pkg::CMD_MERGE : hsmq_pkg::CMD_INSERT;
            push_request(op, hsmq_pkg::SYM_W'($urandom), random_weight(), 1'b0, '0);
        end
    endtask

    task automatic fill_and_drain();
        while (sorted_nodes.size() < hsmq_pkg::QUEUE_DEPTH)
            push_request(hsmq_pkg::CMD_INSERT, hsmq_pkg::SYM_W'($urandom), random_weight(),
                         1'b0, '0);
        repeat (4)
            push_request(hsmq_pkg::CMD_INSERT, hsmq_pkg::SYM_W'($urandom), random_weight(),
                         1'b0, '0);
        while (sorted_nodes.size() > 1)
            push_request(hsmq_pkg::CMD_MERGE, hsmq_pkg::SYM_W'($urandom), $urandom, 1'b0, '0);
        repeat (3)
            push_request(hsmq_pkg::CMD_MERGE, hsmq_pkg::SYM_W'($urandom), $urandom, 1'b0, '0);
    endtask

    // receiver: random stalls plus one long hold-off while requests keep coming
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (!hold_done && results_seen >= 100)
        begin
            hold_done = 1'b1;
            hold_left = 300;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got_result = '{status, node_id, left_id, right_id, node_weight, occupancy};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: st=%0d id=%0d l=%0d r=%0d w=%h occ=%0d",
                             status, node_id, left_id, right_id, node_weight, occupancy);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: exp st=%0d id=%0d l=%0d r=%0d w=%h occ=%0d",
                                 want_result.status, want_result.node_id,
                                 want_result.left_id, want_result.right_id,
                                 want_result.node_weight, want_result.occupancy);
                        $display("          got st=%0d id=%0d l=%0d r=%0d w=%h occ=%0d",
                                 status, node_id, left_id, right_id, node_weight,
                                 occupancy);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 87;
        foreach (DIRECTED[i])
            push_request(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].wt,
                         DIRECTED[i].typed, DIRECTED[i].want);
        wait_drain();
        run_mix(330);
        wait_drain();

        send_idle_pct = 87;
        recv_idle_pct = 35;
        run_mix(330);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_mix(330);
        fill_and_drain();
        wait_drain();

        repeat (20)
            @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("huffman_sorted_merge_queue_top verification clean");
        else
            $display("huffman_sorted_merge_queue_top verification failed");
        $finish;
    end

endmodule
